// File: rtl/tli_pkg.sv
// Shared types and constants for the tank level integrator.
package tli_pkg;

  localparam int unsigned AccW   = 21;
  localparam int unsigned CapW   = 15;
  localparam int unsigned RateW  = 16;
  localparam int unsigned DurW   = 22;
  localparam int unsigned PctW   = 7;
  localparam int unsigned EmpW   = 13;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 22;

  // Product widths: acc * 100 and capacity * 60 * percent.
  localparam int unsigned ProdW  = 28;
  localparam int unsigned Cap60W = 21;
  localparam int unsigned Emp60W = 19;

  // Quotient of level_acc / 60 by reciprocal multiplication.
  localparam int unsigned RecipW  = 22;
  localparam int unsigned RecipSh = 27;
  localparam logic [RecipW-1:0] RecipM = 22'd2236963;

  localparam int unsigned QuoW = 7;
  localparam logic [2:0] DivTopBit = 3'd6;

  localparam logic [CapW-1:0] CapMin = 15'd5000;
  localparam logic [CapW-1:0] CapMax = 15'd30000;
  localparam logic [PctW-1:0] PctSat = 7'd100;

  localparam logic [CfgIdxW-1:0] RegCapacity  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegStopThr   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegStopDur   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegFullPct   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegEmptyThr  = 3'd4;

  typedef struct packed {
    logic             cmd;
    logic [RateW-1:0] inflow_mlpm;
    logic [RateW-1:0] outflow_mlpm;
    logic [TimeW-1:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [CapW-1:0] level_ml;
    logic [PctW-1:0] level_pct;
    logic            is_full;
  } out_item_t;

  typedef struct packed {
    logic [CapW-1:0]  capacity_ml;
    logic [RateW-1:0] stop_threshold_mlpm;
    logic [DurW-1:0]  stop_duration_ms;
    logic [PctW-1:0]  full_fraction_pct;
    logic [EmpW-1:0]  empty_threshold_ml;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic clamp;
    logic full_chk;
    logic empty_chk;
    logic div_init;
    logic div_step;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_last;
  } ctrl_sts_t;

endpackage

// File: rtl/tli_cfg.sv
// Configuration register file for the tank level integrator.
module tli_cfg
  import tli_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q;
  logic [CapW-1:0] cap_wr;

  assign cap_wr = cfg_data_i[CapW-1:0];
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.capacity_ml         <= 15'd20000;
      cfg_q.stop_threshold_mlpm <= 16'd50;
      cfg_q.stop_duration_ms    <= 22'd60000;
      cfg_q.full_fraction_pct   <= 7'd90;
      cfg_q.empty_threshold_ml  <= 13'd200;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegCapacity: begin
          // Out-of-range capacities are dropped so the divisor never reaches zero.
          if (cap_wr >= CapMin && cap_wr <= CapMax) begin
            cfg_q.capacity_ml <= cap_wr;
          end
        end
        RegStopThr:  cfg_q.stop_threshold_mlpm <= cfg_data_i[RateW-1:0];
        RegStopDur:  cfg_q.stop_duration_ms    <= cfg_data_i[DurW-1:0];
        RegFullPct:  cfg_q.full_fraction_pct   <= cfg_data_i[PctW-1:0];
        RegEmptyThr: cfg_q.empty_threshold_ml  <= cfg_data_i[EmpW-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/tli_ctrl.sv
// Sequencing state machine for the tank level integrator.
module tli_ctrl
  import tli_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  ctrl_sts_t sts_i,
  output ctrl_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLAMP,
    S_FULL,
    S_EMPTY,
    S_PREP,
    S_DIV,
    S_DONE
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o           = '0;
    cmd_o.load      = (state_q == S_IDLE) && in_valid_i;
    cmd_o.clamp     = (state_q == S_CLAMP);
    cmd_o.full_chk  = (state_q == S_FULL);
    cmd_o.empty_chk = (state_q == S_EMPTY);
    cmd_o.div_init  = (state_q == S_PREP);
    cmd_o.div_step  = (state_q == S_DIV);
    cmd_o.out_load  = (state_q == S_DONE) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_CLAMP;
          end
        end
        S_CLAMP: state_q <= S_FULL;
        S_FULL:  state_q <= S_EMPTY;
        S_EMPTY: state_q <= S_PREP;
        S_PREP:  state_q <= S_DIV;
        S_DIV: begin
          if (sts_i.div_last) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/tli_dp.sv
// Datapath for the tank level integrator: level state, detection and output arithmetic.
module tli_dp
  import tli_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  in_item_t  in_data_i,
  input  ctrl_cmd_t cmd_i,
  output ctrl_sts_t sts_o,
  output out_item_t out_data_o
);

  in_item_t        in_q;
  logic [AccW-1:0] acc_q;
  logic            full_q;
  logic            stop_active_q;
  logic [TimeW-1:0] stop_start_q;
  logic            low_in_q;
  logic [ProdW-1:0] tgt_q;
  logic [Emp60W-1:0] emp60_q;
  logic [ProdW-1:0] num_q;
  logic [QuoW-1:0]  quo_q;
  logic [2:0]       cnt_q;
  logic [CapW-1:0]  lml_q;
  out_item_t        out_q;

  logic signed [AccW+1:0] lvl_s;
  logic [AccW-1:0]        top;
  logic [AccW-1:0]        lvl_clamped;
  logic [Cap60W-1:0]      cap60;
  logic [Emp60W-1:0]      emp60;
  logic [ProdW-1:0]       acc100;
  logic [TimeW-1:0]       elapsed;
  logic                   full_hit;
  logic                   low_in;
  logic [AccW+RecipW-1:0] recip_prod;
  logic [ProdW-1:0]       div_sh;
  logic [PctW-1:0]        pct;

  assign lvl_s = $signed({2'b00, acc_q}) + $signed({7'd0, in_q.inflow_mlpm})
               - $signed({7'd0, in_q.outflow_mlpm});
  assign top   = {cfg_i.capacity_ml, 6'd0} - {6'd0, cfg_i.capacity_ml};
  assign cap60 = {cfg_i.capacity_ml, 6'd0} - {4'd0, cfg_i.capacity_ml, 2'd0};
  assign emp60 = {cfg_i.empty_threshold_ml, 6'd0}
               - {4'd0, cfg_i.empty_threshold_ml, 2'd0};
  assign low_in = in_q.inflow_mlpm < cfg_i.stop_threshold_mlpm;

  always_comb begin
    if (lvl_s < 0) begin
      lvl_clamped = '0;
    end else if (lvl_s > $signed({2'b00, top})) begin
      lvl_clamped = top;
    end else begin
      lvl_clamped = lvl_s[AccW-1:0];
    end
  end

  assign acc100  = {1'b0, acc_q, 6'd0} + {2'd0, acc_q, 5'd0} + {5'd0, acc_q, 2'd0};
  assign elapsed = in_q.now_ms - stop_start_q;
  assign full_hit = stop_active_q && (elapsed >= {10'd0, cfg_i.stop_duration_ms})
                  && (acc100 >= tgt_q) && !full_q;

  assign recip_prod = {{RecipW{1'b0}}, acc_q} * {{AccW{1'b0}}, RecipM};
  assign div_sh     = {7'd0, cap60} << cnt_q;
  assign pct        = (quo_q > PctSat) ? PctSat : quo_q;

  assign sts_o.div_last = (cnt_q == '0);
  assign out_data_o     = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q         <= '0;
      full_q        <= 1'b0;
      stop_active_q <= 1'b0;
      stop_start_q  <= '0;
    end else begin
      if (cmd_i.clamp) begin
        if (in_q.cmd) begin
          acc_q         <= '0;
          full_q        <= 1'b0;
          stop_active_q <= 1'b0;
          stop_start_q  <= '0;
        end else begin
          acc_q <= lvl_clamped;
          if (low_in) begin
            if (!stop_active_q) begin
              stop_start_q  <= in_q.now_ms;
              stop_active_q <= 1'b1;
            end
          end else begin
            stop_active_q <= 1'b0;
            stop_start_q  <= '0;
            full_q        <= 1'b0;
          end
        end
      end
      if (cmd_i.full_chk && full_hit) begin
        acc_q  <= cap60;
        full_q <= 1'b1;
      end
      if (cmd_i.empty_chk && !in_q.cmd && low_in_q && (acc_q != '0)
          && ({{(AccW-Emp60W){1'b0}}, emp60_q} > acc_q)) begin
        acc_q  <= '0;
        full_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_q <= in_data_i;
    end
    if (cmd_i.clamp) begin
      low_in_q <= low_in;
      tgt_q    <= ProdW'({7'd0, cap60} * {{(ProdW-PctW){1'b0}}, cfg_i.full_fraction_pct});
      emp60_q  <= emp60;
    end
    if (cmd_i.div_init) begin
      num_q <= acc100;
      quo_q <= '0;
      cnt_q <= DivTopBit;
      lml_q <= recip_prod[RecipSh+CapW-1:RecipSh];
    end
    if (cmd_i.div_step) begin
      if (num_q >= div_sh) begin
        num_q        <= num_q - div_sh;
        quo_q[cnt_q] <= 1'b1;
      end
      cnt_q <= cnt_q - 3'd1;
    end
    if (cmd_i.out_load) begin
      out_q.level_ml  <= lml_q;
      out_q.level_pct <= pct;
      out_q.is_full   <= full_q;
    end
  end

endmodule

// File: rtl/tank_level_integrator_full_detect_top.sv
// Top level of the tank level integrator with full and empty detection.
// Each accepted transaction produces one result transaction. The controller
// runs a fixed sequence: the clamp, full check, empty check and divider
// setup, the one-bit-per-cycle restoring divider that forms the level
// percent, loading the output register, and the idle state in which the
// next sample is accepted, so a new sample waits until the last one's
// result has been loaded. The input side accepts only while the
// controller is idle; a pending result holds the controller until it is
// taken. Configuration writes take effect at once and are meant to happen
// only while no sample is in flight.
module tank_level_integrator_full_detect_top
  import tli_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_item_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_item_t           out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t      cfg;
  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  tli_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  tli_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tli_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule

// File: tb/tli_level_tracker.sv
// Watches the tank level integrator's channels, predicts each result and checks it.
`timescale 1ns / 1ps
module tli_level_tracker
  import tli_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  in_item_t            in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  out_item_t           out_data_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int unsigned         err_cnt_o,
  output int unsigned         pend_cnt_o,
  output int unsigned         res_cnt_o,
  output int unsigned         full_cnt_o,
  output int unsigned         empty_cnt_o
);

  cfg_t             tank_cfg;
  logic [AccW-1:0]  acc_q;
  logic             full_q;
  logic             stop_on_q;
  logic [TimeW-1:0] stop_t_q;
  out_item_t        level_q[$];
  out_item_t        want;
  logic [CapW-1:0]  new_cap;
  int unsigned      errs = 0;
  int unsigned      checked = 0;
  int unsigned      fulls = 0;
  int unsigned      empties = 0;

  function automatic out_item_t tank_step(input in_item_t s);
    longint           lvl;
    longint unsigned  top_acc;
    longint unsigned  pct;
    logic             low_in;
    logic [TimeW-1:0] elapsed;
    logic [AccW-1:0]  quo;
    out_item_t        r;
    if (s.cmd) begin
      acc_q = '0;
      full_q = 1'b0;
      stop_on_q = 1'b0;
      stop_t_q = '0;
    end else begin
      lvl = longint'(acc_q);
      lvl = lvl + s.inflow_mlpm;
      lvl = lvl - s.outflow_mlpm;
      top_acc = 64'(tank_cfg.capacity_ml) * 63;
      if (lvl < 0) lvl = 0;
      if (lvl > top_acc) lvl = top_acc;
      acc_q = lvl[AccW-1:0];
      low_in = s.inflow_mlpm < tank_cfg.stop_threshold_mlpm;
      if (low_in) begin
        if (!stop_on_q) begin
          stop_t_q = s.now_ms;
          stop_on_q = 1'b1;
        end
      end else begin
        stop_on_q = 1'b0;
        stop_t_q = '0;
        full_q = 1'b0;
      end
      elapsed = s.now_ms - stop_t_q;
      if (stop_on_q && !full_q && elapsed >= tank_cfg.stop_duration_ms &&
          64'(acc_q) * 100 >=
          64'(tank_cfg.capacity_ml) * 60 * tank_cfg.full_fraction_pct) begin
        acc_q = AccW'(tank_cfg.capacity_ml * 60);
        full_q = 1'b1;
        fulls++;
      end
      if (acc_q < 32'(tank_cfg.empty_threshold_ml) * 60 && low_in && acc_q != 0) begin
        acc_q = '0;
        full_q = 1'b0;
        empties++;
      end
    end
    pct = 64'(acc_q) * 100 / (64'(tank_cfg.capacity_ml) * 60);
    if (pct > 100) pct = 100;
    quo = AccW'(acc_q / 60);
    r.level_ml = quo[CapW-1:0];
    r.level_pct = pct[PctW-1:0];
    r.is_full = full_q;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tank_cfg.capacity_ml = 15'd20000;
      tank_cfg.stop_threshold_mlpm = 16'd50;
      tank_cfg.stop_duration_ms = 22'd60000;
      tank_cfg.full_fraction_pct = 7'd90;
      tank_cfg.empty_threshold_ml = 13'd200;
      acc_q = '0;
      full_q = 1'b0;
      stop_on_q = 1'b0;
      stop_t_q = '0;
      level_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegCapacity: begin
            new_cap = cfg_data_i[CapW-1:0];
            if (new_cap >= CapMin && new_cap <= CapMax) tank_cfg.capacity_ml = new_cap;
          end
          RegStopThr:  tank_cfg.stop_threshold_mlpm = cfg_data_i[RateW-1:0];
          RegStopDur:  tank_cfg.stop_duration_ms = cfg_data_i[DurW-1:0];
          RegFullPct:  tank_cfg.full_fraction_pct = cfg_data_i[PctW-1:0];
          RegEmptyThr: tank_cfg.empty_threshold_ml = cfg_data_i[EmpW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) level_q.push_back(tank_step(in_data_i));
      if (out_valid_i && out_ready_i) begin
        if (level_q.size() == 0) begin
          errs++;
          $display("%0t: result transaction with none pending: expected none, actual %0d/%0d/%0b",
                   $time, out_data_i.level_ml, out_data_i.level_pct, out_data_i.is_full);
        end else begin
          want = level_q.pop_front();
          checked++;
          if (out_data_i.level_ml !== want.level_ml) begin
            errs++;
            $display("%0t: level_ml expected %0d, actual %0d",
                     $time, want.level_ml, out_data_i.level_ml);
          end
          if (out_data_i.level_pct !== want.level_pct) begin
            errs++;
            $display("%0t: level_pct expected %0d, actual %0d",
                     $time, want.level_pct, out_data_i.level_pct);
          end
          if (out_data_i.is_full !== want.is_full) begin
            errs++;
            $display("%0t: is_full expected %0b, actual %0b",
                     $time, want.is_full, out_data_i.is_full);
          end
        end
      end
    end
    err_cnt_o <= errs;
    pend_cnt_o <= level_q.size();
    res_cnt_o <= checked;
    full_cnt_o <= fulls;
    empty_cnt_o <= empties;
  end

endmodule

// File: tb/tank_level_integrator_full_detect_top_tb.sv
// Testbench top: drives samples, register writes and back-pressure, and reports the verdict.
`timescale 1ns / 1ps
module tank_level_integrator_full_detect_top_tb;
  import tli_pkg::*;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned RandSamples = 1800;
  localparam int unsigned DirectedSamples = 21;
  localparam int unsigned DrainWait = 30;
  localparam logic [CfgIdxW-1:0] RegNone = 3'd7;

  typedef enum logic [1:0] {SegFill, SegHold, SegDrain, SegNoise} seg_e;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  in_item_t            in_data_i;
  logic                out_valid_o;
  logic                out_ready_i;
  out_item_t           out_data_o;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  int unsigned      err_cnt;
  int unsigned      pend_cnt;
  int unsigned      res_cnt;
  int unsigned      full_cnt;
  int unsigned      empty_cnt;
  int unsigned      cycle_cnt;
  int unsigned      sent_cnt;
  int unsigned      setting_cnt;
  int unsigned      in_idle_pct;
  int unsigned      out_idle_pct;
  logic [RateW-1:0] cur_thr;
  logic [DurW-1:0]  cur_dur;
  logic [TimeW-1:0] clock_ms;

  tank_level_integrator_full_detect_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  tli_level_tracker u_level_trk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_i  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .err_cnt_o   (err_cnt),
    .pend_cnt_o  (pend_cnt),
    .res_cnt_o   (res_cnt),
    .full_cnt_o  (full_cnt),
    .empty_cnt_o (empty_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt <= CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("No progress after %0d cycles.", cycle_cnt);
    $display("simulation failed");
    $finish;
  end

  initial begin : receiver
    int unsigned took;
    int unsigned hold_left;
    took = 0;
    hold_left = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        took++;
        if (took == 250 || took == 1100) hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= out_idle_pct);
      end
    end
  end

  task automatic send_sample(input in_item_t s);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= s;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent_cnt++;
  endtask

  task automatic push_sample(input logic cmd, input logic [RateW-1:0] inflow,
                             input logic [RateW-1:0] outflow, input logic [TimeW-1:0] now);
    in_item_t s;
    s.cmd = cmd;
    s.inflow_mlpm = inflow;
    s.outflow_mlpm = outflow;
    s.now_ms = now;
    send_sample(s);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pend_cnt != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int unsigned width,
                           input logic [CfgDataW-1:0] val);
    logic [CfgDataW-1:0] mask;
    logic [CfgDataW-1:0] junk;
    mask = (CfgDataW'(1) << width) - 1'b1;
    junk = CfgDataW'($urandom);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= (junk & ~mask) | (val & mask);
    @(posedge clk_i);
  endtask

  task automatic apply_settings(input cfg_t c);
    logic [CapW-1:0] bad_cap;
    case ($urandom_range(0, 3))
      0: bad_cap = '0;
      1: bad_cap = CapMin - 1'b1;
      2: bad_cap = CapMax + 1'b1;
      default: bad_cap = CapW'($urandom_range(30001, 32767));
    endcase
    wait_idle();
    write_reg(RegCapacity, CapW, CfgDataW'(c.capacity_ml));
    write_reg(RegStopThr, RateW, CfgDataW'(c.stop_threshold_mlpm));
    write_reg(RegStopDur, DurW, c.stop_duration_ms);
    write_reg(RegFullPct, PctW, CfgDataW'(c.full_fraction_pct));
    write_reg(RegEmptyThr, EmpW, CfgDataW'(c.empty_threshold_ml));
    write_reg(RegCapacity, CapW, CfgDataW'(bad_cap));
    write_reg(RegNone, CfgDataW, CfgDataW'($urandom));
    cfg_we_i <= 1'b0;
    cur_thr = c.stop_threshold_mlpm;
    cur_dur = c.stop_duration_ms;
    setting_cnt++;
  endtask

  function automatic cfg_t make_setting(input int unsigned k);
    cfg_t c;
    c.capacity_ml = CapW'($urandom_range(5000, 30000));
    c.stop_threshold_mlpm = RateW'($urandom_range(1, 2000));
    c.stop_duration_ms = DurW'($urandom_range(0, 20000));
    c.full_fraction_pct = PctW'($urandom_range(50, 100));
    c.empty_threshold_ml = EmpW'($urandom_range(0, 5000));
    case (k)
      0: begin
        c.capacity_ml = 15'd5000;
        c.stop_threshold_mlpm = 16'd50;
        c.stop_duration_ms = 22'd3000;
        c.full_fraction_pct = 7'd90;
        c.empty_threshold_ml = 13'd200;
      end
      1: begin
        c.capacity_ml = 15'd20000;
        c.stop_threshold_mlpm = 16'd50;
        c.stop_duration_ms = 22'd60000;
        c.full_fraction_pct = 7'd90;
        c.empty_threshold_ml = 13'd200;
      end
      2: begin
        c.capacity_ml = CapMax;
        c.stop_threshold_mlpm = 16'hFFFF;
        c.stop_duration_ms = 22'd3600000;
        c.full_fraction_pct = 7'd100;
        c.empty_threshold_ml = 13'd5000;
      end
      3: begin
        c.capacity_ml = CapMin;
        c.stop_threshold_mlpm = '0;
        c.stop_duration_ms = '0;
        c.full_fraction_pct = 7'd50;
        c.empty_threshold_ml = '0;
      end
      4: begin
        c.stop_threshold_mlpm = RateW'($urandom_range(0, 4000));
        c.stop_duration_ms = '1;
        c.full_fraction_pct = '0;
        c.empty_threshold_ml = '1;
      end
      5: begin
        c.stop_threshold_mlpm = 16'd1;
        c.full_fraction_pct = '1;
      end
      default: ;
    endcase
    return c;
  endfunction

  function automatic in_item_t make_sample(input seg_e seg);
    in_item_t s;
    logic [RateW-1:0] low_in;
    low_in = (cur_thr == 0) ? '0 : RateW'($urandom_range(0, cur_thr - 1'b1));
    s.cmd = 1'b0;
    s.inflow_mlpm = low_in;
    s.outflow_mlpm = '0;
    case (seg)
      SegFill: begin
        s.inflow_mlpm = RateW'($urandom_range(65535, (cur_thr > 20000) ? cur_thr : 20000));
        s.outflow_mlpm = RateW'($urandom_range(0, 3000));
        clock_ms = clock_ms + $urandom_range(0, 2000);
      end
      SegHold: begin
        if ($urandom_range(0, 3) == 0) s.outflow_mlpm = RateW'($urandom_range(0, 500));
        clock_ms = clock_ms + $urandom_range(0, cur_dur / 8 + 1);
      end
      SegDrain: begin
        s.outflow_mlpm = RateW'($urandom_range(1000, 65535));
        clock_ms = clock_ms + $urandom_range(0, 2000);
      end
      default: begin
        s.cmd = ($urandom_range(0, 7) == 0);
        s.inflow_mlpm = RateW'($urandom_range(0, 65535));
        s.outflow_mlpm = RateW'($urandom_range(0, 65535));
        if ($urandom_range(0, 1) == 0) clock_ms = $urandom;
        else clock_ms = clock_ms + $urandom_range(0, 5000);
      end
    endcase
    s.now_ms = clock_ms;
    return s;
  endfunction

  task automatic run_segment(input seg_e seg, input int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_sample(make_sample(seg));
  endtask

  initial begin : stimulus
    int unsigned phase_end;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_idle_pct = 22;
    out_idle_pct = 22;
    sent_cnt = 0;
    setting_cnt = 0;
    clock_ms = '0;
    cur_thr = 16'd50;
    cur_dur = 22'd60000;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset values first, then a small tank driven through fill, full, drain and empty.
    push_sample(1'b1, '1, '1, '1);
    push_sample(1'b0, '0, '1, '0);
    apply_settings(make_setting(0));
    push_sample(1'b0, '0, '0, 32'hFFFFF000);
    for (int unsigned i = 0; i < 5; i++) push_sample(1'b0, '1, '0, 32'hFFFFF100 + i);
    push_sample(1'b0, '0, '0, 32'hFFFFFC00);
    push_sample(1'b0, 16'd49, '0, 32'h00000400);
    push_sample(1'b0, '0, '0, 32'h000007B8);
    push_sample(1'b0, 16'd40, '0, 32'h00001000);
    push_sample(1'b0, 16'd50, 16'd1000, 32'h00001400);
    for (int unsigned i = 0; i < 4; i++) push_sample(1'b0, '0, '1, 32'h00002000 + i);
    push_sample(1'b0, '0, 16'd30000, 32'h00003000);
    push_sample(1'b0, 16'd100, '0, 32'h00003400);
    push_sample(1'b0, 16'd10, '0, 32'h00003800);
    push_sample(1'b1, '0, '0, '0);

    for (int unsigned k = 1; k <= 6; k++) begin
      apply_settings(make_setting(k));
      in_idle_pct = (k == 2) ? 0 : 22;
      out_idle_pct = (k == 2) ? 0 : 22;
      phase_end = DirectedSamples + k * RandSamples / 6;
      while (sent_cnt < phase_end) begin
        if ($urandom_range(0, 9) < 7) begin
          run_segment(SegFill, $urandom_range(5, 40));
          run_segment(SegHold, $urandom_range(5, 30));
          run_segment(SegDrain, $urandom_range(2, 15));
        end else begin
          run_segment(SegNoise, $urandom_range(1, 10));
        end
      end
    end

    wait_idle();
    repeat (DrainWait) @(posedge clk_i);
    $display("Sent %0d samples under %0d register settings; %0d results compared.",
             sent_cnt, setting_cnt, res_cnt);
    $display("Predicted %0d full declarations and %0d snaps to empty, with two long stalls.",
             full_cnt, empty_cnt);
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
